// ----- hdl/dba_pkg.sv -----
`default_nettype none

package dba_pkg;

   localparam int QUEUE_DEPTH    = 64;
   localparam int CMD_FIFO_DEPTH = 4;
   localparam int PROB_BITS      = 8;
   localparam int CODE_BITS      = 12;
   localparam int PROB_MAX       = 128;

   localparam logic [CODE_BITS-1:0] FULL_RANGE = {CODE_BITS{1'b1}};

   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_PUSH   = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_PUSH,
      KIND_DECODE,
      KIND_NONE
   } dba_kind_type;

   typedef struct packed {
      dba_kind_type         kind;
      logic                 code_bit;
      logic [PROB_BITS-1:0] prob;
   } dba_item_type;

   typedef struct packed {
      logic [6:0] queued_bits;
      logic       overflow;
      logic       underflow;
      logic       decoded_bit;
   } dba_result_type;

endpackage

`default_nettype wire

// ----- hdl/dst_binary_arith_decoder.sv -----
// Start, push and no-op transactions go from the idle state to the output state; a decode
// goes through the compare and renormalisation states (n doublings, 0..12) to the output state.
// One transaction is worked at a time; the output state waits while a response is not taken, and the
// renormalisation loop takes one bit from the bit queue memory per cycle while bits remain.
// A 4-entry command queue accepts transactions while the decoder works.
// Reset is synchronous, active high: range 4095, code, bit queue and command queue empty.
`default_nettype none

module dst_binary_arith_decoder #(
   parameter int QUEUE_DEPTH = dba_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   input  wire logic [15:0] req_tdata,   // [0] code_bit, [8:1] probability, [15:9] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [0] decoded_bit, [1] underflow, [2] overflow,
                                         // [9:3] queued_bits, [15:10] zero
);

   logic                    item_valid;
   logic                    item_pop;
   dba_pkg::dba_item_type   item;
   dba_pkg::dba_result_type rsp_result;

   dba_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   dba_back #(
      .QueueDepth (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (rsp_result),
      .rsp_ready  (rsp_tready)
   );

   assign rsp_tdata = {6'd0, rsp_result};

endmodule

`default_nettype wire

// ----- hdl/dba_front.sv -----
`default_nettype none

module dba_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [1:0]          req_tuser,   // cmd
   input  wire logic [15:0]         req_tdata,   // code_bit, probability
   output logic                     item_valid,
   output dba_pkg::dba_item_type    item,
   input  wire logic                item_pop
);

   localparam int Depth = dba_pkg::CMD_FIFO_DEPTH;
   localparam int AW    = $clog2(Depth);
   localparam int CW    = $clog2(Depth + 1);

   dba_pkg::dba_item_type slot_ff [Depth];
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;

   dba_pkg::dba_item_type classified;
   logic [7:0]            prob_raw;
   logic                  push, pop;

   always_comb begin
      prob_raw = req_tdata[8:1];
      case (req_tuser)
         dba_pkg::CMD_START:  classified.kind = dba_pkg::KIND_START;
         dba_pkg::CMD_PUSH:   classified.kind = dba_pkg::KIND_PUSH;
         dba_pkg::CMD_DECODE: classified.kind = dba_pkg::KIND_DECODE;
         default:             classified.kind = dba_pkg::KIND_NONE;
      endcase
      classified.code_bit = req_tdata[0];
      // probability clamped to 1..128
      if (prob_raw == 8'd0) begin
         classified.prob = 8'd1;
      end else if (prob_raw > 8'(dba_pkg::PROB_MAX)) begin
         classified.prob = 8'(dba_pkg::PROB_MAX);
      end else begin
         classified.prob = prob_raw;
      end
   end

   assign req_tready = (count_ff < CW'(Depth));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dba_back.sv -----
`default_nettype none

module dba_back #(
   parameter int QueueDepth = dba_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_valid,
   input  wire dba_pkg::dba_item_type item,
   output logic                       item_pop,
   output logic                       rsp_valid,
   output dba_pkg::dba_result_type    rsp_result,
   input  wire logic                  rsp_ready
);

   localparam int AW = $clog2(QueueDepth);
   localparam int CW = $clog2(QueueDepth + 1);
   localparam int TB = dba_pkg::CODE_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_RENORM,
      ST_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic [TB-1:0]           range_ff, range_in;
   logic [TB-1:0]           code_ff, code_in;
   logic                    skip_ff, skip_in;
   logic [3:0]              preload_ff, preload_in;
   logic [AW-1:0]           head_ff, head_in;
   logic [AW-1:0]           tail_ff, tail_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [TB-1:0]           part_ff, part_in;
   logic [3:0]              renorm_ff, renorm_in;
   logic                    decoded_ff, decoded_in;
   logic                    under_ff, under_in;
   logic                    over_ff, over_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   dba_pkg::dba_result_type rsp_result_ff, rsp_result_in;

   logic                    bit_mem [QueueDepth];
   logic                    rd_bit_ff;
   logic                    wr_en;

   logic [3:0]              scaled;
   logic [TB-1:0]           thr;
   logic                    pop_bit;

   always_comb begin
      state_in      = state_ff;
      range_in      = range_ff;
      code_in       = code_ff;
      skip_in       = skip_ff;
      preload_in    = preload_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      part_in       = part_ff;
      renorm_in     = renorm_ff;
      decoded_in    = decoded_ff;
      under_in      = under_ff;
      over_in       = over_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      item_pop      = 1'b0;
      wr_en         = 1'b0;
      pop_bit       = 1'b0;

      scaled = range_ff[TB-1:dba_pkg::PROB_BITS] | {3'b000, range_ff[dba_pkg::PROB_BITS-1]};
      thr    = (part_ff <= range_ff) ? range_ff - part_ff : '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop   = 1'b1;
               decoded_in = 1'b0;
               under_in   = 1'b0;
               over_in    = 1'b0;
               state_in   = ST_OUT;
               case (item.kind)
                  dba_pkg::KIND_START: begin
                     range_in   = dba_pkg::FULL_RANGE;
                     code_in    = '0;
                     head_in    = '0;
                     tail_in    = '0;
                     count_in   = '0;
                     skip_in    = 1'b1;
                     preload_in = 4'(TB);
                  end
                  dba_pkg::KIND_PUSH: begin
                     if (skip_ff) begin
                        skip_in = 1'b0;
                     end else if (preload_ff != 4'd0) begin
                        code_in    = {code_ff[TB-2:0], item.code_bit};
                        preload_in = preload_ff - 4'd1;
                     end else if (count_ff < CW'(QueueDepth)) begin
                        wr_en    = 1'b1;
                        tail_in  = (tail_ff == AW'(QueueDepth - 1)) ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        over_in = 1'b1;
                     end
                  end
                  dba_pkg::KIND_DECODE: begin
                     // unfinished preload: remaining code bits taken as zeros
                     if (skip_ff || preload_ff != 4'd0) begin
                        code_in    = code_ff << preload_ff;
                        skip_in    = 1'b0;
                        preload_in = 4'd0;
                        under_in   = 1'b1;
                     end
                     part_in  = {8'd0, scaled} * {4'd0, item.prob};
                     state_in = ST_CMP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CMP: begin
            if (code_ff >= thr) begin
               decoded_in = 1'b0;
               code_in    = code_ff - thr;
               range_in   = part_ff;
            end else begin
               decoded_in = 1'b1;
               range_in   = thr;
            end
            renorm_in = 4'd0;
            state_in  = ST_RENORM;
         end
         ST_RENORM: begin
            if (renorm_ff < 4'(TB) && !range_ff[TB-1]) begin
               if (count_ff != '0) begin
                  pop_bit  = rd_bit_ff;
                  head_in  = (head_ff == AW'(QueueDepth - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end else begin
                  under_in = 1'b1;
               end
               range_in  = {range_ff[TB-2:0], 1'b0};
               code_in   = {code_ff[TB-2:0], pop_bit};
               renorm_in = renorm_ff + 4'd1;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_result_in.decoded_bit = decoded_ff;
               rsp_result_in.underflow   = under_ff;
               rsp_result_in.overflow    = over_ff;
               rsp_result_in.queued_bits = 7'(count_ff);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         range_ff     <= dba_pkg::FULL_RANGE;
         code_ff      <= '0;
         skip_ff      <= 1'b0;
         preload_ff   <= 4'd0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         range_ff     <= range_in;
         code_ff      <= code_in;
         skip_ff      <= skip_in;
         preload_ff   <= preload_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      part_ff       <= part_in;
      renorm_ff     <= renorm_in;
      decoded_ff    <= decoded_in;
      under_ff      <= under_in;
      over_ff       <= over_in;
      rsp_result_ff <= rsp_result_in;
   end

   // rd_bit_ff always holds the entry at the head; a write to that entry is forwarded
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bit_mem[tail_ff] <= item.code_bit;
      end
      if (wr_en && tail_ff == head_in) begin
         rd_bit_ff <= item.code_bit;
      end else begin
         rd_bit_ff <= bit_mem[head_in];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

`default_nettype wire
